FILE: src/sstr_pkg.sv
// Shared types and codes for the SQL statement token recogniser.
// Holds the state, token kind and action encodings and the step record.
// No dependencies.
package sstr_pkg;

  typedef enum logic [4:0] {
    ST_INITIAL = 5'd0,
    ST_Q1      = 5'd1,
    ST_Q2      = 5'd2,
    ST_Q3      = 5'd3,
    ST_Q4      = 5'd4,
    ST_Q5      = 5'd5,
    ST_Q6      = 5'd6,
    ST_Q7      = 5'd7,
    ST_Q8      = 5'd8,
    ST_Q9      = 5'd9,
    ST_Q10     = 5'd10,
    ST_Q11     = 5'd11,
    ST_P1      = 5'd12,
    ST_P2      = 5'd13,
    ST_P3      = 5'd14,
    ST_P4      = 5'd15,
    ST_P5      = 5'd16,
    ST_P6      = 5'd17,
    ST_P7      = 5'd18,
    ST_P8      = 5'd19,
    ST_P9      = 5'd20,
    ST_P10     = 5'd21,
    ST_P11     = 5'd22,
    ST_ACCEPT  = 5'd23
  } parse_state_t;

  localparam logic [4:0] TK_INSERT_INTO = 5'd0;
  localparam logic [4:0] TK_SELECT      = 5'd1;
  localparam logic [4:0] TK_IDENT       = 5'd2;
  localparam logic [4:0] TK_LPAREN      = 5'd3;
  localparam logic [4:0] TK_COMMA       = 5'd4;
  localparam logic [4:0] TK_RPAREN      = 5'd5;
  localparam logic [4:0] TK_VALUES      = 5'd6;
  localparam logic [4:0] TK_VALUE       = 5'd7;
  localparam logic [4:0] TK_SEMI        = 5'd8;
  localparam logic [4:0] TK_FROM        = 5'd9;
  localparam logic [4:0] TK_WHERE       = 5'd10;
  localparam logic [4:0] TK_IS          = 5'd11;
  localparam logic [4:0] TK_IS_NOT      = 5'd12;
  localparam logic [4:0] TK_GREATER     = 5'd13;
  localparam logic [4:0] TK_LESSER      = 5'd14;
  localparam logic [4:0] TK_EQUAL       = 5'd15;
  localparam logic [4:0] TK_ORDER_BY    = 5'd16;
  localparam logic [4:0] TK_DESC        = 5'd17;
  localparam logic [4:0] TK_ASC         = 5'd18;

  typedef enum logic [3:0] {
    ACT_NONE           = 4'd0,
    ACT_INSERT_INIT    = 4'd1,
    ACT_SELECT_INIT    = 4'd2,
    ACT_SET_TABLE      = 4'd3,
    ACT_ADD_COLUMN     = 4'd4,
    ACT_ADD_VALUE      = 4'd5,
    ACT_ADD_FUNC_VALUE = 4'd6,
    ACT_ADD_WHERE      = 4'd7,
    ACT_PUSH_FIELD     = 4'd8,
    ACT_PUSH_OP        = 4'd9,
    ACT_PUSH_VALUE     = 4'd10,
    ACT_ADD_ORDER_STMT = 4'd11,
    ACT_ADD_ORDER_BY   = 4'd12,
    ACT_ADD_DIRECTION  = 4'd13
  } action_t;

  typedef struct packed {
    action_t      act;
    logic         uses_text;
    parse_state_t next_state;
  } step_t;

endpackage

FILE: src/sstr_next.sv
// Transition logic of the recogniser: current state and token kind give the
// action, whether it takes the token text, and the next state.
// Depends on sstr_pkg.
module sstr_next (
  input  sstr_pkg::parse_state_t state,
  input  logic [4:0]             kind,
  output sstr_pkg::step_t        step
);

  always_comb begin
    step.act        = sstr_pkg::ACT_NONE;
    step.uses_text  = 1'b0;
    step.next_state = state;
    unique case (state)
      sstr_pkg::ST_INITIAL: begin
        if (kind == sstr_pkg::TK_INSERT_INTO) begin
          step.act = sstr_pkg::ACT_INSERT_INIT;  step.next_state = sstr_pkg::ST_Q1;
        end else if (kind == sstr_pkg::TK_SELECT) begin
          step.act = sstr_pkg::ACT_SELECT_INIT;  step.next_state = sstr_pkg::ST_P1;
        end
      end
      sstr_pkg::ST_Q1: begin
        if (kind == sstr_pkg::TK_IDENT) begin
          step.act = sstr_pkg::ACT_SET_TABLE;  step.uses_text = 1'b1;
          step.next_state = sstr_pkg::ST_Q2;
        end
      end
      sstr_pkg::ST_Q2: begin
        if (kind == sstr_pkg::TK_LPAREN) step.next_state = sstr_pkg::ST_Q3;
      end
      sstr_pkg::ST_Q3: begin
        if (kind == sstr_pkg::TK_IDENT) begin
          step.act = sstr_pkg::ACT_ADD_COLUMN;  step.uses_text = 1'b1;
          step.next_state = sstr_pkg::ST_Q4;
        end
      end
      sstr_pkg::ST_Q4: begin
        if (kind == sstr_pkg::TK_COMMA) step.next_state = sstr_pkg::ST_Q3;
        else if (kind == sstr_pkg::TK_RPAREN) step.next_state = sstr_pkg::ST_Q5;
      end
      sstr_pkg::ST_Q5: begin
        if (kind == sstr_pkg::TK_VALUES) step.next_state = sstr_pkg::ST_Q6;
      end
      sstr_pkg::ST_Q6: begin
        if (kind == sstr_pkg::TK_LPAREN) step.next_state = sstr_pkg::ST_Q7;
      end
      sstr_pkg::ST_Q7: begin
        if (kind == sstr_pkg::TK_VALUE) begin
          step.act = sstr_pkg::ACT_ADD_VALUE;  step.uses_text = 1'b1;
          step.next_state = sstr_pkg::ST_Q10;
        end else if (kind == sstr_pkg::TK_IDENT) begin
          step.act = sstr_pkg::ACT_ADD_FUNC_VALUE;  step.uses_text = 1'b1;
          step.next_state = sstr_pkg::ST_Q8;
        end
      end
      sstr_pkg::ST_Q8: begin
        if (kind == sstr_pkg::TK_LPAREN) step.next_state = sstr_pkg::ST_Q9;
      end
      sstr_pkg::ST_Q9: begin
        if (kind == sstr_pkg::TK_RPAREN) step.next_state = sstr_pkg::ST_Q10;
      end
      sstr_pkg::ST_Q10: begin
        if (kind == sstr_pkg::TK_RPAREN) step.next_state = sstr_pkg::ST_Q11;
        else if (kind == sstr_pkg::TK_COMMA) step.next_state = sstr_pkg::ST_Q7;
      end
      sstr_pkg::ST_Q11: begin
        if (kind == sstr_pkg::TK_SEMI) step.next_state = sstr_pkg::ST_ACCEPT;
      end
      sstr_pkg::ST_P1: begin
        if (kind == sstr_pkg::TK_IDENT) begin
          step.act = sstr_pkg::ACT_ADD_COLUMN;  step.uses_text = 1'b1;
          step.next_state = sstr_pkg::ST_P2;
        end
      end
      sstr_pkg::ST_P2: begin
        if (kind == sstr_pkg::TK_COMMA) step.next_state = sstr_pkg::ST_P1;
        else if (kind == sstr_pkg::TK_FROM) step.next_state = sstr_pkg::ST_P3;
      end
      sstr_pkg::ST_P3: begin
        if (kind == sstr_pkg::TK_IDENT) begin
          step.act = sstr_pkg::ACT_SET_TABLE;  step.uses_text = 1'b1;
          step.next_state = sstr_pkg::ST_P4;
        end
      end
      sstr_pkg::ST_P4: begin
        // A repeated FROM drops back to expecting the table name.
        if (kind == sstr_pkg::TK_WHERE) begin
          step.act = sstr_pkg::ACT_ADD_WHERE;  step.next_state = sstr_pkg::ST_P5;
        end else if (kind == sstr_pkg::TK_FROM) begin
          step.next_state = sstr_pkg::ST_P3;
        end
      end
      sstr_pkg::ST_P5: begin
        if (kind == sstr_pkg::TK_IDENT) begin
          step.act = sstr_pkg::ACT_PUSH_FIELD;  step.uses_text = 1'b1;
          step.next_state = sstr_pkg::ST_P6;
        end
      end
      sstr_pkg::ST_P6: begin
        if (kind == sstr_pkg::TK_IS || kind == sstr_pkg::TK_IS_NOT ||
            kind == sstr_pkg::TK_GREATER || kind == sstr_pkg::TK_LESSER ||
            kind == sstr_pkg::TK_EQUAL) begin
          step.act = sstr_pkg::ACT_PUSH_OP;  step.uses_text = 1'b1;
          step.next_state = sstr_pkg::ST_P7;
        end
      end
      sstr_pkg::ST_P7: begin
        if (kind == sstr_pkg::TK_VALUE) begin
          step.act = sstr_pkg::ACT_PUSH_VALUE;  step.uses_text = 1'b1;
          step.next_state = sstr_pkg::ST_P8;
        end
      end
      sstr_pkg::ST_P8: begin
        if (kind == sstr_pkg::TK_SEMI) begin
          step.next_state = sstr_pkg::ST_ACCEPT;
        end else if (kind == sstr_pkg::TK_ORDER_BY) begin
          step.act = sstr_pkg::ACT_ADD_ORDER_STMT;  step.next_state = sstr_pkg::ST_P9;
        end
      end
      sstr_pkg::ST_P9: begin
        if (kind == sstr_pkg::TK_IDENT) begin
          step.act = sstr_pkg::ACT_ADD_ORDER_BY;  step.uses_text = 1'b1;
          step.next_state = sstr_pkg::ST_P10;
        end
      end
      sstr_pkg::ST_P10: begin
        if (kind == sstr_pkg::TK_SEMI) begin
          step.next_state = sstr_pkg::ST_ACCEPT;
        end else if (kind == sstr_pkg::TK_DESC || kind == sstr_pkg::TK_ASC) begin
          step.act = sstr_pkg::ACT_ADD_DIRECTION;  step.uses_text = 1'b1;
          step.next_state = sstr_pkg::ST_P11;
        end
      end
      sstr_pkg::ST_P11: begin
        if (kind == sstr_pkg::TK_SEMI) step.next_state = sstr_pkg::ST_ACCEPT;
      end
      default: begin
        step.next_state = state;
      end
    endcase
  end

endmodule

FILE: src/sql_statement_token_recognizer.sv
// A token beat waits in the input register and moves to the result/state register
// when that is empty or out_tready is high. Throughput: one token per cycle while
// the result side is ready; the state loop closes through the transition logic.
// Reset (rst_n low, synchronous) empties both registers and returns the
// recogniser to its initial state. Depends on sstr_pkg and sstr_next.
module sql_statement_token_recognizer #(
  parameter  int TEXT_TAG_BITS = 16,
  localparam int InW  = ((TEXT_TAG_BITS + 7) / 8) * 8,
  localparam int OutW = ((TEXT_TAG_BITS + 5 + 7) / 8) * 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [InW-1:0]  in_tdata,   // text_tag
  input  logic [4:0]      in_tuser,   // token_kind
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [OutW-1:0] out_tdata,  // action_text, new_state
  output logic [3:0]      out_tuser,  // action_code
  output logic            out_tlast   // accepted
);

  logic                     in_vld_r;
  logic [4:0]               in_kind_r;
  logic [TEXT_TAG_BITS-1:0] in_tag_r;
  logic                     out_vld_r;
  sstr_pkg::action_t        out_act_r;
  logic [TEXT_TAG_BITS-1:0] out_text_r;
  sstr_pkg::parse_state_t   parse_state_r;
  sstr_pkg::step_t          step;
  logic                     advance;

  sstr_next u_next (
    .state (parse_state_r),
    .kind  (in_kind_r),
    .step  (step)
  );

  assign advance   = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || !out_vld_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r      <= 1'b0;
      out_vld_r     <= 1'b0;
      parse_state_r <= sstr_pkg::ST_INITIAL;
    end else begin
      if (in_tready) begin
        in_vld_r <= in_tvalid;
      end
      if (advance) begin
        out_vld_r     <= 1'b1;
        parse_state_r <= step.next_state;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_kind_r <= in_tuser;
      in_tag_r  <= in_tdata[TEXT_TAG_BITS-1:0];
    end
    if (advance) begin
      out_act_r  <= step.act;
      out_text_r <= step.uses_text ? in_tag_r : '0;
    end
  end

  always_comb begin
    out_tdata                                  = '0;
    out_tdata[TEXT_TAG_BITS-1:0]               = out_text_r;
    out_tdata[TEXT_TAG_BITS+4:TEXT_TAG_BITS]   = parse_state_r;
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_act_r;
  assign out_tlast  = (parse_state_r == sstr_pkg::ST_ACCEPT);

  a_accept_absorbs: assert property (@(posedge clk) disable iff (!rst_n)
    parse_state_r == sstr_pkg::ST_ACCEPT |=> parse_state_r == sstr_pkg::ST_ACCEPT)
    else $error("recogniser left the accept state");

  a_state_moves_with_beat: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(parse_state_r))
    else $error("state changed without a token moving to the result register");

  a_no_action_no_text: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_act_r == sstr_pkg::ACT_NONE |-> out_text_r == '0)
    else $error("text carried on a beat with no action");

  a_result_slot_kept: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_tready |=> out_vld_r)
    else $error("result beat dropped while stalled");

endmodule

FILE: tb/tb_sql_statement_token_recognizer.sv
// Self-checking testbench for the SQL statement token recogniser.
// Drives token beats, predicts every result beat and checks them in order.
// Depends on sstr_pkg and sql_statement_token_recognizer.
module tb_sql_statement_token_recognizer;

  localparam int TAG_W = 16;
  localparam int OUT_W = 24;
  localparam int N_RANDOM = 430;
  localparam int FINISH_WINDOW = 60;
  localparam int STALL_LIMIT = 2000;
  localparam logic [4:0] TK_OTHER = 5'd19;
  localparam logic [4:0] KIND_TOP = 5'd31;

  typedef struct {
    logic [4:0]       kind;
    logic [TAG_W-1:0] tag;
    bit               drain;
  } token_beat_t;

  typedef struct {
    sstr_pkg::action_t      act;
    logic [TAG_W-1:0]       text;
    sstr_pkg::parse_state_t state;
    logic                   accepted;
  } step_result_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [TAG_W-1:0] in_tdata = '0;
  logic [4:0]       in_tuser = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic [3:0]       out_tuser;
  logic             out_tlast;

  token_beat_t            pending_tokens[$];
  step_result_t           expected_steps[$];
  sstr_pkg::parse_state_t parse_track = sstr_pkg::ST_INITIAL;
  int                     n_accepted = 0;
  int                     n_results = 0;
  int                     errors = 0;
  int                     burst_left = 1;
  int                     gap_left = 0;
  int                     idle_cycles = 0;
  int                     cycle_count = 0;
  logic [15:0]            ready_pattern = 16'hFFFF;

  sql_statement_token_recognizer #(.TEXT_TAG_BITS(TAG_W)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #4 clk = ~clk;

  function automatic step_result_t next_parse(sstr_pkg::parse_state_t s, logic [4:0] k,
                                              logic [TAG_W-1:0] tag);
    step_result_t r;
    logic         with_text;
    r.act = sstr_pkg::ACT_NONE;
    r.state = s;
    with_text = 1'b0;
    case (s)
      sstr_pkg::ST_INITIAL: begin
        if (k == sstr_pkg::TK_INSERT_INTO) begin
          r.act = sstr_pkg::ACT_INSERT_INIT;
          r.state = sstr_pkg::ST_Q1;
        end else if (k == sstr_pkg::TK_SELECT) begin
          r.act = sstr_pkg::ACT_SELECT_INIT;
          r.state = sstr_pkg::ST_P1;
        end
      end
      sstr_pkg::ST_Q1: begin
        if (k == sstr_pkg::TK_IDENT) begin
          r.act = sstr_pkg::ACT_SET_TABLE;
          with_text = 1'b1;
          r.state = sstr_pkg::ST_Q2;
        end
      end
      sstr_pkg::ST_Q2: if (k == sstr_pkg::TK_LPAREN) r.state = sstr_pkg::ST_Q3;
      sstr_pkg::ST_Q3: begin
        if (k == sstr_pkg::TK_IDENT) begin
          r.act = sstr_pkg::ACT_ADD_COLUMN;
          with_text = 1'b1;
          r.state = sstr_pkg::ST_Q4;
        end
      end
      sstr_pkg::ST_Q4: begin
        if (k == sstr_pkg::TK_COMMA) r.state = sstr_pkg::ST_Q3;
        else if (k == sstr_pkg::TK_RPAREN) r.state = sstr_pkg::ST_Q5;
      end
      sstr_pkg::ST_Q5: if (k == sstr_pkg::TK_VALUES) r.state = sstr_pkg::ST_Q6;
      sstr_pkg::ST_Q6: if (k == sstr_pkg::TK_LPAREN) r.state = sstr_pkg::ST_Q7;
      sstr_pkg::ST_Q7: begin
        if (k == sstr_pkg::TK_VALUE) begin
          r.act = sstr_pkg::ACT_ADD_VALUE;
          with_text = 1'b1;
          r.state = sstr_pkg::ST_Q10;
        end else if (k == sstr_pkg::TK_IDENT) begin
          r.act = sstr_pkg::ACT_ADD_FUNC_VALUE;
          with_text = 1'b1;
          r.state = sstr_pkg::ST_Q8;
        end
      end
      sstr_pkg::ST_Q8: if (k == sstr_pkg::TK_LPAREN) r.state = sstr_pkg::ST_Q9;
      sstr_pkg::ST_Q9: if (k == sstr_pkg::TK_RPAREN) r.state = sstr_pkg::ST_Q10;
      sstr_pkg::ST_Q10: begin
        if (k == sstr_pkg::TK_RPAREN) r.state = sstr_pkg::ST_Q11;
        else if (k == sstr_pkg::TK_COMMA) r.state = sstr_pkg::ST_Q7;
      end
      sstr_pkg::ST_Q11: if (k == sstr_pkg::TK_SEMI) r.state = sstr_pkg::ST_ACCEPT;
      sstr_pkg::ST_P1: begin
        if (k == sstr_pkg::TK_IDENT) begin
          r.act = sstr_pkg::ACT_ADD_COLUMN;
          with_text = 1'b1;
          r.state = sstr_pkg::ST_P2;
        end
      end
      sstr_pkg::ST_P2: begin
        if (k == sstr_pkg::TK_COMMA) r.state = sstr_pkg::ST_P1;
        else if (k == sstr_pkg::TK_FROM) r.state = sstr_pkg::ST_P3;
      end
      sstr_pkg::ST_P3: begin
        if (k == sstr_pkg::TK_IDENT) begin
          r.act = sstr_pkg::ACT_SET_TABLE;
          with_text = 1'b1;
          r.state = sstr_pkg::ST_P4;
        end
      end
      sstr_pkg::ST_P4: begin
        if (k == sstr_pkg::TK_WHERE) begin
          r.act = sstr_pkg::ACT_ADD_WHERE;
          r.state = sstr_pkg::ST_P5;
        end else if (k == sstr_pkg::TK_FROM) begin
          r.state = sstr_pkg::ST_P3;
        end
      end
      sstr_pkg::ST_P5: begin
        if (k == sstr_pkg::TK_IDENT) begin
          r.act = sstr_pkg::ACT_PUSH_FIELD;
          with_text = 1'b1;
          r.state = sstr_pkg::ST_P6;
        end
      end
      sstr_pkg::ST_P6: begin
        if (k inside {sstr_pkg::TK_IS, sstr_pkg::TK_IS_NOT, sstr_pkg::TK_GREATER,
                      sstr_pkg::TK_LESSER, sstr_pkg::TK_EQUAL}) begin
          r.act = sstr_pkg::ACT_PUSH_OP;
          with_text = 1'b1;
          r.state = sstr_pkg::ST_P7;
        end
      end
      sstr_pkg::ST_P7: begin
        if (k == sstr_pkg::TK_VALUE) begin
          r.act = sstr_pkg::ACT_PUSH_VALUE;
          with_text = 1'b1;
          r.state = sstr_pkg::ST_P8;
        end
      end
      sstr_pkg::ST_P8: begin
        if (k == sstr_pkg::TK_SEMI) begin
          r.state = sstr_pkg::ST_ACCEPT;
        end else if (k == sstr_pkg::TK_ORDER_BY) begin
          r.act = sstr_pkg::ACT_ADD_ORDER_STMT;
          r.state = sstr_pkg::ST_P9;
        end
      end
      sstr_pkg::ST_P9: begin
        if (k == sstr_pkg::TK_IDENT) begin
          r.act = sstr_pkg::ACT_ADD_ORDER_BY;
          with_text = 1'b1;
          r.state = sstr_pkg::ST_P10;
        end
      end
      sstr_pkg::ST_P10: begin
        if (k == sstr_pkg::TK_SEMI) begin
          r.state = sstr_pkg::ST_ACCEPT;
        end else if (k == sstr_pkg::TK_DESC || k == sstr_pkg::TK_ASC) begin
          r.act = sstr_pkg::ACT_ADD_DIRECTION;
          with_text = 1'b1;
          r.state = sstr_pkg::ST_P11;
        end
      end
      sstr_pkg::ST_P11: if (k == sstr_pkg::TK_SEMI) r.state = sstr_pkg::ST_ACCEPT;
      default: ;
    endcase
    r.text = with_text ? tag : '0;
    r.accepted = (r.state == sstr_pkg::ST_ACCEPT);
    return r;
  endfunction

  // Picks a token that fits the state. Until finishing is allowed the choice
  // stays on the value and FROM loops so that the statement runs long.
  function automatic logic [4:0] fitting_kind(sstr_pkg::parse_state_t s, bit finish_ok);
    logic [4:0] k;
    case (s)
      sstr_pkg::ST_INITIAL:
        k = $urandom_range(0, 1) ? sstr_pkg::TK_SELECT : sstr_pkg::TK_INSERT_INTO;
      sstr_pkg::ST_Q1, sstr_pkg::ST_Q3, sstr_pkg::ST_P1, sstr_pkg::ST_P3, sstr_pkg::ST_P5,
      sstr_pkg::ST_P9: k = sstr_pkg::TK_IDENT;
      sstr_pkg::ST_Q2, sstr_pkg::ST_Q6, sstr_pkg::ST_Q8: k = sstr_pkg::TK_LPAREN;
      sstr_pkg::ST_Q4:
        k = ($urandom_range(0, 2) == 0) ? sstr_pkg::TK_RPAREN : sstr_pkg::TK_COMMA;
      sstr_pkg::ST_Q5: k = sstr_pkg::TK_VALUES;
      sstr_pkg::ST_Q7, sstr_pkg::ST_P7:
        k = ($urandom_range(0, 1) || s == sstr_pkg::ST_P7) ? sstr_pkg::TK_VALUE
                                                            : sstr_pkg::TK_IDENT;
      sstr_pkg::ST_Q9: k = sstr_pkg::TK_RPAREN;
      sstr_pkg::ST_Q10:
        k = (finish_ok && $urandom_range(0, 1)) ? sstr_pkg::TK_RPAREN : sstr_pkg::TK_COMMA;
      sstr_pkg::ST_Q11, sstr_pkg::ST_P11: k = sstr_pkg::TK_SEMI;
      sstr_pkg::ST_P2:
        k = ($urandom_range(0, 2) == 0) ? sstr_pkg::TK_COMMA : sstr_pkg::TK_FROM;
      sstr_pkg::ST_P4:
        k = (finish_ok && $urandom_range(0, 1)) ? sstr_pkg::TK_WHERE : sstr_pkg::TK_FROM;
      sstr_pkg::ST_P6: begin
        case ($urandom_range(0, 4))
          0: k = sstr_pkg::TK_IS;
          1: k = sstr_pkg::TK_IS_NOT;
          2: k = sstr_pkg::TK_GREATER;
          3: k = sstr_pkg::TK_LESSER;
          default: k = sstr_pkg::TK_EQUAL;
        endcase
      end
      sstr_pkg::ST_P8: k = $urandom_range(0, 1) ? sstr_pkg::TK_SEMI : sstr_pkg::TK_ORDER_BY;
      sstr_pkg::ST_P10: begin
        case ($urandom_range(0, 2))
          0: k = sstr_pkg::TK_SEMI;
          1: k = sstr_pkg::TK_DESC;
          default: k = sstr_pkg::TK_ASC;
        endcase
      end
      default: k = 5'($urandom_range(0, KIND_TOP));
    endcase
    return k;
  endfunction

  task automatic note_error(string msg);
    errors++;
    if (errors <= 10) $display("mismatch: %s", msg);
  endtask

  initial begin : stimulus
    sstr_pkg::parse_state_t plan;
    step_result_t           r;
    token_beat_t            b;
    int                     d;
    int                     i;
    plan = sstr_pkg::ST_INITIAL;
    // Kinds 2 to 20 and 31, none of which opens a statement, alternating between the two tag extremes.
    for (d = sstr_pkg::TK_IDENT; d <= TK_OTHER + 2; d++) begin
      b.kind = (d > TK_OTHER + 1) ? KIND_TOP : d[4:0];
      b.tag = d[0] ? {TAG_W{1'b1}} : '0;
      b.drain = 1'b0;
      pending_tokens.push_back(b);
    end
    for (i = 0; i < N_RANDOM; i++) begin
      if ($urandom_range(0, 99) < 85) begin
        b.kind = fitting_kind(plan, i >= N_RANDOM - FINISH_WINDOW);
      end else begin
        b.kind = 5'($urandom_range(0, KIND_TOP));
      end
      case ($urandom_range(0, 7))
        0: b.tag = '0;
        1: b.tag = {TAG_W{1'b1}};
        default: b.tag = TAG_W'($urandom);
      endcase
      b.drain = (i == 0 || i == 250);
      r = next_parse(plan, b.kind, b.tag);
      plan = r.state;
      pending_tokens.push_back(b);
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_tokens.size() != 0 || n_results != n_accepted) @(posedge clk);
    repeat (10) @(posedge clk);
    if (expected_steps.size() != 0) begin
      note_error($sformatf("%0d results never arrived", expected_steps.size()));
    end
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  always @(posedge clk) begin : token_driver
    logic         fire;
    logic         offer;
    token_beat_t  head;
    step_result_t r;
    fire = in_tvalid && in_tready;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (fire) begin
        head = pending_tokens.pop_front();
        r = next_parse(parse_track, head.kind, head.tag);
        parse_track = r.state;
        expected_steps.push_back(r);
        n_accepted <= n_accepted + 1;
        burst_left = burst_left - 1;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          if ((n_accepted >= 300 && n_accepted < 380) || $urandom_range(0, 3) == 0) begin
            gap_left = 0;
          end else begin
            gap_left = $urandom_range(1, 6);
          end
        end
      end
      offer = 1'b0;
      if (in_tvalid && !fire) begin
        offer = 1'b1;
      end else if (pending_tokens.size() != 0) begin
        if (pending_tokens[0].drain && (fire || n_results != n_accepted)) begin
          offer = 1'b0;
        end else if (gap_left != 0) begin
          gap_left = gap_left - 1;
        end else begin
          offer = 1'b1;
        end
      end
      in_tvalid <= offer;
      if (offer && !(in_tvalid && !fire)) begin
        in_tdata <= pending_tokens[0].tag;
        in_tuser <= pending_tokens[0].kind;
      end
    end
  end

  always @(posedge clk) begin : result_ready
    cycle_count <= cycle_count + 1;
    if (cycle_count % 64 == 0) begin
      if ($urandom_range(0, 3) == 0) ready_pattern <= 16'hFFFF;
      else ready_pattern <= 16'($urandom) | 16'h0101;
    end else begin
      ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
    end
    out_tready <= ready_pattern[0];
  end

  always @(posedge clk) begin : result_monitor
    step_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      n_results <= n_results + 1;
      if (expected_steps.size() == 0) begin
        note_error($sformatf("result beat with none expected: act %0d text %h state %0d",
                             out_tuser, out_tdata[15:0], out_tdata[20:16]));
      end else begin
        want = expected_steps.pop_front();
        if (out_tuser !== want.act || out_tdata[15:0] !== want.text ||
            out_tdata[20:16] !== want.state || out_tlast !== want.accepted) begin
          note_error($sformatf(
            "exp act %0d text %h state %0d acc %b, got act %0d text %h state %0d acc %b",
            want.act, want.text, want.state, want.accepted,
            out_tuser, out_tdata[15:0], out_tdata[20:16], out_tlast));
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

endmodule

FILE: filelist.f
src/sstr_pkg.sv
src/sstr_next.sv
src/sql_statement_token_recognizer.sv
tb/tb_sql_statement_token_recognizer.sv
